### hw/rtl/assert_macros.svh
// Assertion helpers for the checker file kdlpr_checker.sv.
// Each macro checks on the rising edge of clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge.
`define KD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle leads to a result in the next cycle.
`define KD_ASSERT_NEXT(lbl, pre, post, msg) \
  `KD_ASSERT(lbl, (pre) |=> (post), msg)

`endif

### hw/rtl/kdlpr_pkg.sv
`default_nettype none
package kdlpr_pkg;

  // Fixed field widths and slot counts
  localparam int MaxKeys  = 4;
  localparam int KeyIdxW  = 2;
  localparam int KindW    = 2;
  localparam int LongW    = 16;
  localparam int PeriodW  = 8;
  localparam int CntW     = 7;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 16;
  localparam int SlotsN   = 2 * MaxKeys;
  localparam int SelW     = 3;

  // Event kinds
  localparam logic [KindW-1:0] EvPress  = 2'd0;
  localparam logic [KindW-1:0] EvLong   = 2'd1;
  localparam logic [KindW-1:0] EvRepeat = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgLong0   = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgLong3   = 4'd3;
  localparam logic [CfgIdxW-1:0] CfgRepeat0 = 4'd4;
  localparam logic [CfgIdxW-1:0] CfgRepeat3 = 4'd7;

  // Register reset values
  localparam logic [LongW-1:0]   LongReset   = 16'd100;
  localparam logic [PeriodW-1:0] RepeatReset = 8'd10;

  // Events one key raises in one tick: press, then long or repeat
  typedef struct packed {
    logic press;
    logic second;
    logic rpt;
  } lane_evt_t;

endpackage
`default_nettype wire

### hw/rtl/kdlpr_lane.sv
`default_nettype none
module kdlpr_lane #(
  parameter int FILTER_TICKS = 5
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              accept_i,
  input  wire logic                              level_i,
  input  wire logic [kdlpr_pkg::LongW-1:0]       long_time_i,
  input  wire logic [kdlpr_pkg::PeriodW-1:0]     repeat_period_i,
  input  wire logic                              cfg_clr_i,
  output kdlpr_pkg::lane_evt_t                   evt_o
);

  localparam logic [kdlpr_pkg::CntW-1:0] FtC    = kdlpr_pkg::CntW'(FILTER_TICKS);
  localparam logic [kdlpr_pkg::CntW-1:0] Ft2C   = kdlpr_pkg::CntW'(2 * FILTER_TICKS);
  localparam logic [kdlpr_pkg::CntW-1:0] CntRst = kdlpr_pkg::CntW'(FILTER_TICKS / 2);

  logic [kdlpr_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic                          held_q, held_d;
  logic [kdlpr_pkg::LongW-1:0]   hold_q, hold_d;
  logic [kdlpr_pkg::PeriodW-1:0] rep_q, rep_d;
  logic [kdlpr_pkg::LongW-1:0]   hold_inc;
  logic [kdlpr_pkg::PeriodW-1:0] rep_inc;

  assign hold_inc = hold_q + 1'b1;
  assign rep_inc  = rep_q + 1'b1;

  // Debounce, hold and repeat update for one tick
  always_comb begin
    cnt_d  = cnt_q;
    held_d = held_q;
    hold_d = hold_q;
    rep_d  = rep_q;
    evt_o  = '0;
    if (level_i) begin
      if (cnt_q < FtC) begin
        cnt_d = FtC;
      end else if (cnt_q < Ft2C) begin
        cnt_d = cnt_q + 1'b1;
      end else begin
        if (!held_q) begin
          held_d      = 1'b1;
          evt_o.press = 1'b1;
        end
        if (long_time_i != '0) begin
          if (hold_q < long_time_i) begin
            hold_d       = hold_inc;
            evt_o.second = (hold_inc == long_time_i);
          end else if (repeat_period_i != '0) begin
            if (rep_inc >= repeat_period_i) begin
              rep_d        = '0;
              evt_o.second = 1'b1;
              evt_o.rpt    = 1'b1;
            end else begin
              rep_d = rep_inc;
            end
          end
        end
      end
    end else begin
      if (cnt_q > FtC) begin
        cnt_d = FtC;
      end else if (cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
      end else begin
        held_d = 1'b0;
      end
      hold_d = '0;
      rep_d  = '0;
    end
  end

  // Commit state on an accepted tick; else a settings write clears the repeat count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= CntRst;
      held_q <= 1'b0;
      hold_q <= '0;
      rep_q  <= '0;
    end else if (accept_i) begin
      cnt_q  <= cnt_d;
      held_q <= held_d;
      hold_q <= hold_d;
      rep_q  <= rep_d;
    end else if (cfg_clr_i) begin
      rep_q  <= '0;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/kdlpr_merge.sv
`default_nettype none
module kdlpr_merge (
  input  wire logic                                            clk_i,
  input  wire logic                                            rst_ni,
  input  wire logic                                            accept_i,
  input  kdlpr_pkg::lane_evt_t [kdlpr_pkg::MaxKeys-1:0]        evt_i,
  output logic                                                 tick_ok_o,
  input  wire logic                                            out_stall_i,
  output logic                                                 out_valid_o,
  output logic [kdlpr_pkg::KeyIdxW-1:0]                        out_key_index_o,
  output logic [kdlpr_pkg::KindW-1:0]                          out_event_kind_o,
  output logic                                                 out_last_event_o
);

  logic [kdlpr_pkg::SlotsN-1:0]  pend_q, pend_d, pend_new, rest;
  logic [kdlpr_pkg::MaxKeys-1:0] rpt_q, rpt_d, rpt_new;
  logic [kdlpr_pkg::SelW-1:0]    sel;
  logic                          out_load, pop;
  logic                          valid_q;
  logic [kdlpr_pkg::KeyIdxW-1:0] key_q;
  logic [kdlpr_pkg::KindW-1:0]   kind_q, kind_d;
  logic                          last_q;

  // Flatten lane events into slots: press of key k, then its second event
  always_comb begin
    for (int k = 0; k < kdlpr_pkg::MaxKeys; k++) begin
      pend_new[2*k]   = evt_i[k].press;
      pend_new[2*k+1] = evt_i[k].second;
      rpt_new[k]      = evt_i[k].rpt;
    end
  end

  // Pick the lowest pending slot
  always_comb begin
    sel = '0;
    for (int j = kdlpr_pkg::SlotsN - 1; j >= 0; j--) begin
      if (pend_q[j]) sel = kdlpr_pkg::SelW'(j);
    end
  end

  assign out_load  = !valid_q || !out_stall_i;
  assign pop       = out_load && (pend_q != '0);
  assign rest      = pend_q & ~(kdlpr_pkg::SlotsN'(1) << sel);
  assign tick_ok_o = (pend_q == '0) || (pop && (rest == '0));

  always_comb begin
    pend_d = pend_q;
    rpt_d  = rpt_q;
    if (accept_i) begin
      pend_d = pend_new;
      rpt_d  = rpt_new;
    end else if (pop) begin
      pend_d = rest;
    end
  end

  always_comb begin
    if (!sel[0]) begin
      kind_d = kdlpr_pkg::EvPress;
    end else if (rpt_q[sel[kdlpr_pkg::SelW-1:1]]) begin
      kind_d = kdlpr_pkg::EvRepeat;
    end else begin
      kind_d = kdlpr_pkg::EvLong;
    end
  end

  // Hold pending slots; drop each as it moves to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (out_load) valid_q <= pop;
    end
  end

  // Output payload and repeat kinds
  always_ff @(posedge clk_i) begin
    rpt_q <= rpt_d;
    if (pop) begin
      key_q  <= sel[kdlpr_pkg::SelW-1:1];
      kind_q <= kind_d;
      last_q <= (rest == '0);
    end
  end

  assign out_valid_o      = valid_q;
  assign out_key_index_o  = key_q;
  assign out_event_kind_o = kind_q;
  assign out_last_event_o = last_q;

endmodule
`default_nettype wire

### hw/rtl/key_debounce_long_press_repeat.sv
`default_nettype none
// Key debounce with long press and auto repeat.
// Input channel (in_valid_i / in_stall_o): one scan tick per item, bit k of
// key_levels_i is the raw level of key k. Output channel (out_valid_o /
// out_stall_i): one key event per item, tagged with key index, kind
// (press, long, repeat) and a flag on the final event of its tick.
// Settings port (cfg_valid_i / cfg_ready_o): indexes 0..3 set the long time
// of each key, 4..7 the repeat period; other indexes are dropped. Writing a
// key's setting clears its repeat count. Write only while idle.
// One lane per key updates its state in the cycle a tick is accepted; the
// merge stage loads the tick's events into its event queue and moves them
// to the output register one per cycle while the receiver does not stall,
// draining the queue one slot per cycle; the next tick is taken in the
// cycle the last event moves to the output register.
// Ticks that raise no event are taken every cycle.
// Reset sets each debounce count to half the filter ticks, clears held, hold
// and repeat counts, and loads long time 100 and repeat period 10.
// While the receiver stalls, the output event holds and at most one more
// tick's events wait in the queue; then in_stall_o rises.
module key_debounce_long_press_repeat #(
  parameter int KEYS         = 4,
  parameter int FILTER_TICKS = 5
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [KEYS-1:0]                   key_levels_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [kdlpr_pkg::KeyIdxW-1:0]          out_key_index_o,
  output logic [kdlpr_pkg::KindW-1:0]            out_event_kind_o,
  output logic                                   out_last_event_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [kdlpr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [kdlpr_pkg::CfgDataW-1:0]    cfg_data_i
);

  logic [kdlpr_pkg::LongW-1:0]   long_q [kdlpr_pkg::MaxKeys];
  logic [kdlpr_pkg::PeriodW-1:0] per_q  [kdlpr_pkg::MaxKeys];
  logic                          cfg_we, cfg_hit;
  logic                          tick_ok, accept;
  kdlpr_pkg::lane_evt_t [kdlpr_pkg::MaxKeys-1:0] evt;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_idx_i inside {[kdlpr_pkg::CfgLong0:kdlpr_pkg::CfgRepeat3]};

  // Settings registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < kdlpr_pkg::MaxKeys; k++) begin
        long_q[k] <= kdlpr_pkg::LongReset;
        per_q[k]  <= kdlpr_pkg::RepeatReset;
      end
    end else if (cfg_we) begin
      if (cfg_idx_i inside {[kdlpr_pkg::CfgLong0:kdlpr_pkg::CfgLong3]}) begin
        long_q[cfg_idx_i[1:0]] <= cfg_data_i;
      end else if (cfg_idx_i inside {[kdlpr_pkg::CfgRepeat0:kdlpr_pkg::CfgRepeat3]}) begin
        per_q[cfg_idx_i[1:0]] <= cfg_data_i[kdlpr_pkg::PeriodW-1:0];
      end
    end
  end

  assign accept     = in_valid_i && tick_ok;
  assign in_stall_o = !tick_ok;

  // One lane per key
  for (genvar k = 0; k < kdlpr_pkg::MaxKeys; k++) begin : g_lane
    if (k < KEYS) begin : g_used
      kdlpr_lane #(
        .FILTER_TICKS(FILTER_TICKS)
      ) u_lane (
        .clk_i          (clk_i),
        .rst_ni         (rst_ni),
        .accept_i       (accept),
        .level_i        (key_levels_i[k]),
        .long_time_i    (long_q[k]),
        .repeat_period_i(per_q[k]),
        .cfg_clr_i      (cfg_we && cfg_hit && (cfg_idx_i[1:0] == 2'(k))),
        .evt_o          (evt[k])
      );
    end else begin : g_unused
      assign evt[k] = '0;
    end
  end

  // Serialize lane events in key order
  kdlpr_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .evt_i           (evt),
    .tick_ok_o       (tick_ok),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_key_index_o (out_key_index_o),
    .out_event_kind_o(out_event_kind_o),
    .out_last_event_o(out_last_event_o)
  );

endmodule
`default_nettype wire

### hw/rtl/kdlpr_checker.sv
`default_nettype none
`include "assert_macros.svh"
module kdlpr_checker #(
  parameter int KEYS = 4
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic [kdlpr_pkg::KeyIdxW-1:0]     out_key_index_o,
  input wire logic [kdlpr_pkg::KindW-1:0]       out_event_kind_o,
  input wire logic                              out_last_event_o
);

  // Hold a stalled event
  `KD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_key_index_o) && $stable(out_event_kind_o) && $stable(out_last_event_o), "stalled event changed")

  // Only defined kinds leave the block
  `KD_ASSERT(a_kind_ok, out_valid_o |-> (out_event_kind_o == kdlpr_pkg::EvPress || out_event_kind_o == kdlpr_pkg::EvLong || out_event_kind_o == kdlpr_pkg::EvRepeat), "undefined event kind")

  // Events only for keys in use
  `KD_ASSERT(a_key_ok, out_valid_o |-> (32'(out_key_index_o) < KEYS), "event for unused key")

  // Events of one tick leave without gaps
  `KD_ASSERT_NEXT(a_no_gap, out_valid_o && !out_stall_i && !out_last_event_o, out_valid_o, "gap inside a tick's events")

endmodule

bind key_debounce_long_press_repeat kdlpr_checker #(
  .KEYS(KEYS)
) u_kdlpr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_key_index_o (out_key_index_o),
  .out_event_kind_o(out_event_kind_o),
  .out_last_event_o(out_last_event_o)
);
`default_nettype wire

### dv/tb_key_debounce_long_press_repeat.sv
module tb_key_debounce_long_press_repeat;

  localparam int NumKeys     = 4;
  localparam int FilterTicks = 5;
  localparam int HalfPeriod  = 5;
  localparam int ResetCycles = 12;
  localparam int IdlePct     = 11;
  localparam int SettleCycles = 12;
  localparam int CycleLimit  = 300000;

  // Field widths of the block
  localparam int KeyIdxW  = kdlpr_pkg::KeyIdxW;
  localparam int KindW    = kdlpr_pkg::KindW;
  localparam int LongW    = kdlpr_pkg::LongW;
  localparam int PeriodW  = kdlpr_pkg::PeriodW;
  localparam int CntW     = kdlpr_pkg::CntW;
  localparam int CfgIdxW  = kdlpr_pkg::CfgIdxW;
  localparam int CfgDataW = kdlpr_pkg::CfgDataW;

  // Indexes past the register list: writes there are dropped
  localparam logic [CfgIdxW-1:0] CfgFirstUnused = 4'd8;
  localparam logic [CfgIdxW-1:0] CfgLastIdx     = 4'd15;

  typedef struct packed {
    logic [KeyIdxW-1:0] key;
    logic [KindW-1:0]   kind;
    logic               last;
  } key_event_t;

  // Per-key debounce, hold and repeat tracking; predicts the events of each tick
  class key_event_tracker;
    logic [LongW-1:0]   long_time [NumKeys];
    logic [PeriodW-1:0] repeat_period [NumKeys];
    logic [CntW-1:0]    debounce [NumKeys];
    bit                 held [NumKeys];
    logic [LongW-1:0]   hold_cnt [NumKeys];
    logic [PeriodW-1:0] rpt_cnt [NumKeys];
    key_event_t         expected_events [$];
    int                 mismatches;

    function new();
      for (int k = 0; k < NumKeys; k++) begin
        long_time[k]     = kdlpr_pkg::LongReset;
        repeat_period[k] = kdlpr_pkg::RepeatReset;
        debounce[k]      = CntW'(FilterTicks / 2);
        held[k]          = 1'b0;
        hold_cnt[k]      = '0;
        rpt_cnt[k]       = '0;
      end
      mismatches = 0;
    endfunction

    task log_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
    endtask

    function void note_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx <= kdlpr_pkg::CfgLong3) begin
        long_time[idx - kdlpr_pkg::CfgLong0] = data;
        rpt_cnt[idx - kdlpr_pkg::CfgLong0]   = '0;
      end else if (idx <= kdlpr_pkg::CfgRepeat3) begin
        repeat_period[idx - kdlpr_pkg::CfgRepeat0] = data[PeriodW-1:0];
        rpt_cnt[idx - kdlpr_pkg::CfgRepeat0]       = '0;
      end
    endfunction

    function void add_event(int k, logic [KindW-1:0] kind);
      key_event_t ev;
      ev.key  = KeyIdxW'(k);
      ev.kind = kind;
      ev.last = 1'b0;
      expected_events.push_back(ev);
    endfunction

    // Advance every key by one tick and queue the events it raises
    function void note_tick(logic [NumKeys-1:0] levels);
      int cnt;
      int first;
      first = expected_events.size();
      for (int k = 0; k < NumKeys; k++) begin
        cnt = debounce[k];
        if (levels[k]) begin
          if (cnt < FilterTicks) begin
            cnt = FilterTicks;
          end else if (cnt < 2 * FilterTicks) begin
            cnt++;
          end else begin
            if (!held[k]) begin
              held[k] = 1'b1;
              add_event(k, kdlpr_pkg::EvPress);
            end
            if (long_time[k] != 0) begin
              if (hold_cnt[k] < long_time[k]) begin
                hold_cnt[k]++;
                if (hold_cnt[k] == long_time[k]) add_event(k, kdlpr_pkg::EvLong);
              end else if (repeat_period[k] != 0) begin
                rpt_cnt[k]++;
                if (rpt_cnt[k] >= repeat_period[k]) begin
                  rpt_cnt[k] = '0;
                  add_event(k, kdlpr_pkg::EvRepeat);
                end
              end
            end
          end
        end else begin
          if (cnt > FilterTicks) cnt = FilterTicks;
          else if (cnt != 0) cnt--;
          else held[k] = 1'b0;
          hold_cnt[k] = '0;
          rpt_cnt[k]  = '0;
        end
        debounce[k] = CntW'(cnt);
      end
      // Mark the final event of this tick
      if (expected_events.size() > first) expected_events[$].last = 1'b1;
    endfunction

    task check_event(logic [KeyIdxW-1:0] key, logic [KindW-1:0] kind, logic last);
      key_event_t exp_ev;
      if (expected_events.size() == 0) begin
        log_mismatch($sformatf("unexpected event key %0d kind %0d last %0d", key, kind, last));
        return;
      end
      exp_ev = expected_events.pop_front();
      if (key !== exp_ev.key)
        log_mismatch($sformatf("key_index %0d, want %0d", key, exp_ev.key));
      if (kind !== exp_ev.kind)
        log_mismatch($sformatf("event_kind %0d, want %0d (key %0d)", kind, exp_ev.kind,
                               exp_ev.key));
      if (last !== exp_ev.last)
        log_mismatch($sformatf("last_event %0d, want %0d (key %0d)", last, exp_ev.last,
                               exp_ev.key));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [NumKeys-1:0]  key_levels_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [KeyIdxW-1:0]  out_key_index_o;
  logic [KindW-1:0]    out_event_kind_o;
  logic                out_last_event_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  key_event_tracker tracker;
  bit               quiet;
  int               cycles;

  key_debounce_long_press_repeat #(
    .KEYS         (NumKeys),
    .FILTER_TICKS (FilterTicks)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .key_levels_i     (key_levels_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_key_index_o  (out_key_index_o),
    .out_event_kind_o (out_event_kind_o),
    .out_last_event_o (out_last_event_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Check each accepted event and stall the result channel at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_event(out_key_index_o, out_event_kind_o, out_last_event_o);
    out_stall_i <= !quiet && ($urandom_range(0, 99) < IdlePct);
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("key_debounce_long_press_repeat test failed");
      $finish;
    end
  end

  // Present one tick, idling at random first, and hold it until taken
  task send_tick(input logic [NumKeys-1:0] levels);
    while (!quiet && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    key_levels_i <= levels;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_tick(levels);
  endtask

  // Keep cfg_valid_i high across back-to-back writes; end_writes drops it
  task write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.note_write(idx, data);
  endtask

  task end_writes();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Set both registers of one key; upper data bits of the period are don't-care
  task set_key(input int k, input logic [LongW-1:0] lt, input logic [PeriodW-1:0] rp);
    write_reg(CfgIdxW'(kdlpr_pkg::CfgLong0 + k), lt);
    write_reg(CfgIdxW'(kdlpr_pkg::CfgRepeat0 + k), {8'($urandom_range(0, 255)), rp});
  endtask

  // Stop sending, wait for every expected event, then let the pipeline settle
  task drain();
    in_valid_i <= 1'b0;
    while (tracker.expected_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Runs of held key masks with release gaps and occasional one-tick chatter
  task run_keys(input int n_ticks);
    logic [NumKeys-1:0] mask;
    logic [NumKeys-1:0] levels;
    int                 run;
    int                 b;
    while (n_ticks > 0) begin
      mask = ($urandom_range(0, 99) < 30) ? '0 : NumKeys'($urandom_range(1, 15));
      run  = (mask == 0) ? $urandom_range(1, 12) : $urandom_range(1, 25);
      for (int i = 0; i < run && n_ticks > 0; i++) begin
        levels = mask;
        if ($urandom_range(0, 99) < 8) begin
          b = $urandom_range(0, NumKeys - 1);
          levels[b] = ~levels[b];
        end
        send_tick(levels);
        n_ticks--;
      end
    end
  endtask

  initial begin
    tracker      = new();
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    key_levels_i = '0;
    out_stall_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    quiet        = 1'b0;
    cycles       = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Press and long together, long without repeat, long disabled, long out of reach
    set_key(0, 16'd1, 8'd1);
    set_key(1, 16'd2, 8'd0);
    set_key(2, 16'd0, 8'd3);
    write_reg(kdlpr_pkg::CfgLong3, 16'hFFFF);
    write_reg(kdlpr_pkg::CfgRepeat3, 16'hFFFF);
    write_reg(CfgFirstUnused, 16'h0000);
    write_reg(CfgLastIdx, 16'hFFFF);
    end_writes();
    send_tick(4'b0000);
    repeat (12) send_tick(4'b1111);
    drain();

    // Lower long time of a held key below its hold count: skip to repeat
    write_reg(kdlpr_pkg::CfgLong3, 16'd2);
    write_reg(kdlpr_pkg::CfgRepeat3, 16'd1);
    end_writes();
    repeat (4) send_tick(4'b1111);
    send_tick(4'b1010);
    send_tick(4'b0101);
    send_tick(4'b0000);
    send_tick(4'b0000);
    drain();

    // Random phases; keys may stay held across the register writes
    for (int p = 0; p < 6; p++) begin
      if (p == 5) begin
        set_key(0, 16'd0, 8'd5);
        set_key(1, 16'hFFFF, 8'd255);
        set_key(2, 16'd1, 8'd255);
        set_key(3, 16'd2, 8'd0);
      end else begin
        for (int k = 0; k < NumKeys; k++) begin
          if (p == 0)
            set_key(k, 16'd1, 8'($urandom_range(1, 3)));
          else
            set_key(k, ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 12)),
                    8'($urandom_range(0, 6)));
        end
      end
      write_reg(CfgIdxW'(CfgFirstUnused + $urandom_range(0, 7)), 16'($urandom));
      end_writes();
      quiet <= (p == 2);
      run_keys(32);
      drain();
    end

    if (tracker.mismatches == 0)
      $display("key_debounce_long_press_repeat test passed");
    else
      $display("key_debounce_long_press_repeat test failed");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/kdlpr_pkg.sv
hw/rtl/kdlpr_lane.sv
hw/rtl/kdlpr_merge.sv
hw/rtl/key_debounce_long_press_repeat.sv
hw/rtl/kdlpr_checker.sv
dv/tb_key_debounce_long_press_repeat.sv
